// ===== src/ss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ss_pkg: shared types for the stack sorter
// Item structs, controller state and the link between neighbouring cells.
// ----------------------------------------------------------------------------
package ss_pkg;

   localparam int unsigned ValueWidth = 32;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic                         last;
   } req_item_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] sorted_value;
      logic                         end_of_run;
      logic                         overflow;
   } rsp_item_type;

   // what one cell shows its neighbours
   typedef struct packed {
      logic                         valid;
      logic                         gt;
      logic signed [ValueWidth-1:0] value;
   } ss_link_type;

   // broadcast to every cell
   typedef struct packed {
      logic                         insert;
      logic                         pop;
      logic signed [ValueWidth-1:0] value;
   } ss_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } ss_state_type;

endpackage
`default_nettype wire

// ===== src/stack_sorter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_sorter_top: bounded sort of signed values, smallest first
// Values load into a sorted chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Values are taken one item per cycle in ST_LOAD: each cell compares the
// incoming value with its own and shifts, so the chain stays sorted as it fills.
// The item marked last closes the set; the chain then drains through cell 0,
// one result per cycle while rsp_stall is low, and no item is taken
// until the final result has left cell 0. Up to DEPTH values are held; later
// values of the set are dropped and every result of that set carries overflow.
// ----------------------------------------------------------------------------
module stack_sorter_top #(
   parameter int unsigned DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire ss_pkg::req_item_type req_item,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output ss_pkg::rsp_item_type      rsp_item
);

   ss_pkg::ss_state_type state_ff, state_in;
   logic                 dropped_ff, dropped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ss_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   ss_pkg::ss_ctrl_type  ctrl;
   ss_pkg::ss_link_type  links [DEPTH];
   logic [DEPTH-1:0]     valid_vec;
   logic                 req_accept, full, pop;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         ss_pkg::ss_link_type prev_l, next_l;
         if (g == 0) begin : g_first
            assign prev_l = '{valid: 1'b1, gt: 1'b0, value: '0};
         end else begin : g_mid
            assign prev_l = links[g-1];
         end
         if (g == DEPTH - 1) begin : g_end
            assign next_l = '{valid: 1'b0, gt: 1'b0, value: '0};
         end else begin : g_more
            assign next_l = links[g+1];
         end
         ss_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .prev_link (prev_l),
            .next_link (next_l),
            .own_link  (links[g])
         );
         assign valid_vec[g] = links[g].valid;
      end
   endgenerate

   assign full       = valid_vec[DEPTH-1];
   assign req_stall  = (state_ff == ss_pkg::ST_DRAIN);
   assign req_accept = req_valid && !req_stall;
   assign pop        = (state_ff == ss_pkg::ST_DRAIN) && valid_vec[0]
                       && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      ctrl         = '{insert: req_accept && !full, pop: pop, value: req_item.value};
      unique case (state_ff)
         ss_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_item.last) begin
                  state_in = ss_pkg::ST_DRAIN;
               end
            end
         end
         ss_pkg::ST_DRAIN: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{sorted_value: links[0].value,
                                end_of_run:   !valid_vec[1],
                                overflow:     dropped_ff};
               if (!valid_vec[1]) begin
                  state_in   = ss_pkg::ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ss_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ss_pkg::ST_LOAD;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // occupied cells always form a run from cell 0
   a_thermo : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("cell occupancy has a hole");

   a_drain_nonempty : assert property (@(posedge clock) disable iff (reset)
      state_ff == ss_pkg::ST_DRAIN |-> valid_vec[0])
      else $error("draining with an empty chain");

   a_run_end : assert property (@(posedge clock) disable iff (reset)
      (pop && !valid_vec[1]) |=> (state_ff == ss_pkg::ST_LOAD) && !dropped_ff
                                 && rsp_item_ff.end_of_run && valid_vec == '0)
      else $error("run did not close cleanly");

   a_insert : assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> valid_vec[0] && $countones(valid_vec) == $countones($past(valid_vec)) + 1)
      else $error("insert did not add one entry");

endmodule
`default_nettype wire

// ===== src/ss_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ss_cell: one compare-and-shift cell
// Holds one value. On insert it keeps, takes the broadcast value or takes its
// lower neighbour's value; on pop it takes its upper neighbour's value.
// ----------------------------------------------------------------------------
module ss_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire ss_pkg::ss_ctrl_type ctrl,
   input  wire ss_pkg::ss_link_type prev_link,
   input  wire ss_pkg::ss_link_type next_link,
   output ss_pkg::ss_link_type      own_link
);

   logic                                 valid_ff, valid_in;
   logic signed [ss_pkg::ValueWidth-1:0] value_ff, value_in;
   logic                                 gt;

   assign gt = valid_ff && (value_ff > ctrl.value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.pop) begin
         valid_in = next_link.valid;
         value_in = next_link.value;
      end else if (ctrl.insert) begin
         valid_in = valid_ff | prev_link.valid;
         if (prev_link.gt) begin
            value_in = prev_link.value;
         end else if (!valid_ff || gt) begin
            value_in = ctrl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign own_link = '{valid: valid_ff, gt: gt, value: value_ff};

endmodule
`default_nettype wire
